// ===== hw/rtl/dltq_pkg.sv =====
package dltq_pkg;

    // operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_POP    = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // result status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_NOTFOUND = 2'd2;

    localparam int DELTA_W = 16;
    localparam int EVENT_W = 8;

    // one queue entry as stored in the entry memory
    typedef struct packed {
        logic [DELTA_W-1:0] delta;
        logic [EVENT_W-1:0] ev;
    } entry_t;

endpackage

// ===== hw/rtl/delta_list_timer_queue.sv =====
// Delta-list timer queue: one request at a time, result strobed on done for one cycle.
// Refused requests are answered from idle. Pop, insert and delete cost one pass over
// the entry memory, one entry a cycle (one read and one write port, registered read).
// A new request is taken in the cycle its predecessor's result shows. The receiver
// cannot stall the result.
// Reset (rst_n low, async) empties the queue; memory contents are left as they are.
module delta_list_timer_queue
    import dltq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          op,
    input  logic [DELTA_W-1:0]  delay,
    input  logic [EVENT_W-1:0]  event_id,
    output logic                done,
    output logic [1:0]          status,
    output logic [EVENT_W-1:0]  out_event,
    output logic [DELTA_W-1:0]  out_delta
);

    // address width and count width (count must reach QUEUE_DEPTH)
    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // Sequencer states.
    //   INS_WALK  : walk from the soonest entry, subtracting deltas
    //   INS_SHPRE : issue read of the latest entry before the shift
    //   INS_SHIFT : move entries one place later, latest first
    //   PUT_OLD   : rewrite the displaced entry with its reduced delta
    //   PUT_NEW   : write the new entry, close the request
    //   DEL_SCAN  : search for the first matching event
    //   DEL_FOLD  : fold the removed delta into the next entry
    //   DEL_SHIFT : move entries one place sooner (also used by pop)
    //   POP       : capture the soonest entry
    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_WALK,
        S_INS_SHPRE,
        S_INS_SHIFT,
        S_PUT_OLD,
        S_PUT_NEW,
        S_DEL_SCAN,
        S_DEL_FOLD,
        S_DEL_SHIFT,
        S_POP
    } state_t;

    // entry memory: one write port, one registered read port
    entry_t entry_mem [QUEUE_DEPTH];
    entry_t rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    entry_t        mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= entry_mem[rd_addr];
    end

    // control and working registers
    state_t             state_reg,     state_next;
    logic [AW-1:0]      idx_reg,       idx_next;      // entry whose read data is valid now
    logic [AW-1:0]      pos_reg,       pos_next;      // insert / delete position
    logic [CW-1:0]      count_reg,     count_next;
    logic [1:0]         op_reg,        op_next;
    logic [DELTA_W-1:0] rem_reg,       rem_next;      // remaining delay during the walk
    logic [EVENT_W-1:0] ev_reg,        ev_next;
    logic [DELTA_W-1:0] cur_delta_reg, cur_delta_next;
    logic [EVENT_W-1:0] cur_ev_reg,    cur_ev_next;
    logic               done_reg,      done_next;
    logic [1:0]         status_reg,    status_next;
    logic [EVENT_W-1:0] out_event_reg, out_event_next;
    logic [DELTA_W-1:0] out_delta_reg, out_delta_next;

    // one bit wider than the count so position + 2 never wraps
    logic [CW:0]        count_x;
    logic [CW:0]        idx_p1;
    logic [CW:0]        pos_p2;
    logic [DELTA_W:0]   fold_sum;
    logic [DELTA_W-1:0] fold_sat;

    assign count_x  = {1'b0, count_reg};
    assign idx_p1   = (CW+1)'(idx_reg) + (CW+1)'(1);
    assign pos_p2   = (CW+1)'(pos_reg) + (CW+1)'(2);
    assign fold_sum = {1'b0, cur_delta_reg} + {1'b0, rd_data_reg.delta};
    assign fold_sat = fold_sum[DELTA_W] ? {DELTA_W{1'b1}} : fold_sum[DELTA_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        count_next     = count_reg;
        op_next        = op_reg;
        rem_next       = rem_reg;
        ev_next        = ev_reg;
        cur_delta_next = cur_delta_reg;
        cur_ev_next    = cur_ev_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        out_event_next = out_event_reg;
        out_delta_next = out_delta_reg;
        rd_addr        = '0;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = rd_data_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                // address 0 is read here so the walk, scan or pop starts with data
                rd_addr = '0;
                if (start)
                begin
                    op_next        = op;
                    rem_next       = delay;
                    ev_next        = event_id;
                    idx_next       = '0;
                    out_event_next = '0;
                    out_delta_next = '0;
                    unique case (op)
                        OP_INSERT:
                        begin
                            if (count_reg == CW'(QUEUE_DEPTH))
                            begin
                                done_next   = 1'b1;
                                status_next = STAT_FULL;
                            end
                            else if (count_reg == '0)
                            begin
                                pos_next   = '0;
                                state_next = S_PUT_NEW;
                            end
                            else
                            begin
                                state_next = S_INS_WALK;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = STAT_NOTFOUND;
                            end
                            else
                            begin
                                state_next = S_DEL_SCAN;
                            end
                        end
                        OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = STAT_NOTFOUND;
                            end
                            else
                            begin
                                state_next = S_POP;
                            end
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            status_next = STAT_NOTFOUND;
                        end
                    endcase
                end
            end

            S_INS_WALK:
            begin
                // read ahead; a read past the stop point is simply unused
                rd_addr = idx_reg + AW'(1);
                if (rem_reg >= rd_data_reg.delta)
                begin
                    rem_next = rem_reg - rd_data_reg.delta;
                    if (idx_p1 == count_x)
                    begin
                        // goes after every entry
                        pos_next   = AW'(count_reg);
                        state_next = S_PUT_NEW;
                    end
                    else
                    begin
                        idx_next = idx_reg + AW'(1);
                    end
                end
                else
                begin
                    pos_next       = idx_reg;
                    cur_delta_next = rd_data_reg.delta;
                    cur_ev_next    = rd_data_reg.ev;
                    state_next     = (idx_p1 < count_x) ? S_INS_SHPRE : S_PUT_OLD;
                end
            end

            S_INS_SHPRE:
            begin
                rd_addr    = AW'(count_reg - CW'(1));
                idx_next   = AW'(count_reg - CW'(1));
                state_next = S_INS_SHIFT;
            end

            S_INS_SHIFT:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg + AW'(1);
                mem_wdata = rd_data_reg;
                if (idx_reg == pos_reg + AW'(1))
                begin
                    state_next = S_PUT_OLD;
                end
                else
                begin
                    rd_addr  = idx_reg - AW'(1);
                    idx_next = idx_reg - AW'(1);
                end
            end

            S_PUT_OLD:
            begin
                mem_we          = 1'b1;
                mem_waddr       = pos_reg + AW'(1);
                mem_wdata.delta = cur_delta_reg - rem_reg;
                mem_wdata.ev    = cur_ev_reg;
                state_next      = S_PUT_NEW;
            end

            S_PUT_NEW:
            begin
                mem_we          = 1'b1;
                mem_waddr       = pos_reg;
                mem_wdata.delta = rem_reg;
                mem_wdata.ev    = ev_reg;
                count_next      = count_reg + CW'(1);
                done_next       = 1'b1;
                status_next     = STAT_OK;
                state_next      = S_IDLE;
            end

            S_DEL_SCAN:
            begin
                rd_addr = idx_reg + AW'(1);
                if (rd_data_reg.ev == ev_reg)
                begin
                    if (idx_p1 < count_x)
                    begin
                        pos_next       = idx_reg;
                        cur_delta_next = rd_data_reg.delta;
                        state_next     = S_DEL_FOLD;
                    end
                    else
                    begin
                        // latest entry: its delta is dropped
                        count_next  = count_reg - CW'(1);
                        done_next   = 1'b1;
                        status_next = STAT_OK;
                        state_next  = S_IDLE;
                    end
                end
                else if (idx_p1 == count_x)
                begin
                    done_next   = 1'b1;
                    status_next = STAT_NOTFOUND;
                    state_next  = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end

            S_DEL_FOLD:
            begin
                // read data is the entry after the removed one
                mem_we          = 1'b1;
                mem_waddr       = pos_reg;
                mem_wdata.delta = fold_sat;
                mem_wdata.ev    = rd_data_reg.ev;
                if (pos_p2 < count_x)
                begin
                    rd_addr    = pos_reg + AW'(2);
                    idx_next   = pos_reg + AW'(2);
                    state_next = S_DEL_SHIFT;
                end
                else
                begin
                    count_next  = count_reg - CW'(1);
                    done_next   = 1'b1;
                    status_next = STAT_OK;
                    state_next  = S_IDLE;
                end
            end

            S_DEL_SHIFT:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg - AW'(1);
                mem_wdata = rd_data_reg;
                if (idx_p1 == count_x)
                begin
                    count_next  = count_reg - CW'(1);
                    done_next   = 1'b1;
                    status_next = STAT_OK;
                    state_next  = S_IDLE;
                    if (op_reg == OP_POP)
                    begin
                        out_event_next = cur_ev_reg;
                        out_delta_next = cur_delta_reg;
                    end
                end
                else
                begin
                    rd_addr  = idx_reg + AW'(1);
                    idx_next = idx_reg + AW'(1);
                end
            end

            S_POP:
            begin
                cur_delta_next = rd_data_reg.delta;
                cur_ev_next    = rd_data_reg.ev;
                if (count_reg == CW'(1))
                begin
                    count_next     = '0;
                    done_next      = 1'b1;
                    status_next    = STAT_OK;
                    out_event_next = rd_data_reg.ev;
                    out_delta_next = rd_data_reg.delta;
                    state_next     = S_IDLE;
                end
                else
                begin
                    rd_addr    = AW'(1);
                    idx_next   = AW'(1);
                    state_next = S_DEL_SHIFT;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            pos_reg       <= '0;
            count_reg     <= '0;
            op_reg        <= OP_INSERT;
            rem_reg       <= '0;
            ev_reg        <= '0;
            cur_delta_reg <= '0;
            cur_ev_reg    <= '0;
            done_reg      <= 1'b0;
            status_reg    <= STAT_OK;
            out_event_reg <= '0;
            out_delta_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            pos_reg       <= pos_next;
            count_reg     <= count_next;
            op_reg        <= op_next;
            rem_reg       <= rem_next;
            ev_reg        <= ev_next;
            cur_delta_reg <= cur_delta_next;
            cur_ev_reg    <= cur_ev_next;
            done_reg      <= done_next;
            status_reg    <= status_next;
            out_event_reg <= out_event_next;
            out_delta_reg <= out_delta_next;
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign status    = status_reg;
    assign out_event = out_event_reg;
    assign out_delta = out_delta_reg;

endmodule

// ===== hw/rtl/dltq_checker.sv =====
module dltq_checker
    import dltq_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic [1:0]          op,
    input logic                done,
    input logic [1:0]          status,
    input logic [EVENT_W-1:0]  out_event,
    input logic [DELTA_W-1:0]  out_delta
);

    // a finished multi-cycle request always shows its result as busy drops
    a_done_on_release: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    // status is always one of the defined codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == STAT_OK || status == STAT_FULL || status == STAT_NOTFOUND))
        else $error("undefined status code");

    // a refused or failed request never reports entry data
    a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != STAT_OK) |-> (out_event == '0 && out_delta == '0))
        else $error("failed request reports entry data");

    // unused op code answers next cycle and leaves the block idle
    a_unused_op: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && op == OP_UNUSED) |=> (done && status == STAT_NOTFOUND && !busy))
        else $error("unused op code not refused at once");

    // no result without a request in progress or just accepted
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && !(start && !busy)) |=> !done)
        else $error("result without a request");

endmodule

bind delta_list_timer_queue dltq_checker u_dltq_checker (.*);
